@@ rtl/vns_pkg.sv @@
// Shared constants and types for the value noise sampler.
// No dependencies; every module of the block imports this package.
`default_nettype none

package vns_pkg;

	localparam int COORD_W = 32;
	localparam int NOISE_W = 26;
	localparam int CORNER_W = 10;
	localparam int WEIGHT_W = 16;
	localparam int WPROD_W = 2 * (WEIGHT_W + 1);
	localparam int BPROD_W = CORNER_W + WPROD_W;
	localparam int MIX_W = 26;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int NUM_CORNERS = 4;

	localparam logic [31:0] HASH_K1 = 32'd374761393;
	localparam logic [31:0] HASH_K2 = 32'd668265263;
	localparam logic [31:0] HASH_K3 = 32'd1442695041;
	localparam logic [31:0] HASH_K4 = 32'd1274126177;
	localparam logic [NOISE_W-1:0] OUT_MAX = 26'd67043328;

	// Corner order used everywhere: (x, y), (x+1, y), (x, y+1), (x+1, y+1).
	typedef enum logic [1:0] {
		CORNER_A = 2'd0,
		CORNER_B = 2'd1,
		CORNER_C = 2'd2,
		CORNER_D = 2'd3
	} corner_t;

	// Load enables of the five pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

`default_nettype wire

@@ rtl/vns_hash.sv @@
// Corner hash: lattice multiplies, seed mix, xorshift, last multiply and xor fold.
// Depends on vns_pkg; corner values are valid out of stage 3.
`default_nettype none

module vns_hash (
	input  wire logic                          clk,
	input  wire vns_pkg::adv_t                 adv,
	input  wire logic [vns_pkg::COORD_W-1:0]   x_cell,
	input  wire logic [vns_pkg::COORD_W-1:0]   y_cell,
	input  wire logic [31:0]                   seed_mix,
	output logic [vns_pkg::CORNER_W-1:0]       corner [vns_pkg::NUM_CORNERS]
);
	import vns_pkg::*;

	logic [31:0] xk_s1;
	logic [31:0] yk_s1;
	logic [31:0] base;
	logic [31:0] h0 [NUM_CORNERS];
	logic [31:0] g_s2 [NUM_CORNERS];
	logic [MIX_W-1:0] m_s3 [NUM_CORNERS];
	logic [31:0] m_full [NUM_CORNERS];

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			xk_s1 <= x_cell * HASH_K1;
			yk_s1 <= y_cell * HASH_K2;
		end
	end

	// The x+1 and y+1 corners differ from the base sum by the constants alone.
	always_comb begin
		base = xk_s1 + yk_s1 + seed_mix;
		h0[CORNER_A] = base;
		h0[CORNER_B] = base + HASH_K1;
		h0[CORNER_C] = base + HASH_K2;
		h0[CORNER_D] = base + HASH_K1 + HASH_K2;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				g_s2[k] <= h0[k] ^ (h0[k] >> 13);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			m_full[k] = g_s2[k] * HASH_K4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				m_s3[k] <= m_full[k][MIX_W-1:0];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			corner[k] = m_s3[k][CORNER_W-1:0] ^ m_s3[k][16 +: CORNER_W];
		end
	end

endmodule

`default_nettype wire

@@ rtl/vns_ease.sv @@
// Smoothstep easing of both fractions and the four bilinear weight products.
// Depends on vns_pkg; weight products are valid out of stage 3.
`default_nettype none

module vns_ease #(
	parameter int FRAC_BITS = vns_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire vns_pkg::adv_t                 adv,
	input  wire logic [FRAC_BITS-1:0]          x_frac,
	input  wire logic [FRAC_BITS-1:0]          y_frac,
	output logic [vns_pkg::WPROD_W-1:0]        wprod [vns_pkg::NUM_CORNERS]
);
	import vns_pkg::*;

	localparam int FB = FRAC_BITS;
	localparam logic [FB+1:0] THREE_ONE = (FB+2)'(3) << FB;
	localparam logic [WEIGHT_W:0] UNIT = (WEIGHT_W+1)'(1) << WEIGHT_W;

	logic [FB-1:0]       f_s1 [2];
	logic [FB-1:0]       f2_s1 [2];
	logic [2*FB-1:0]     sq [2];
	logic [FB+1:0]       t [2];
	logic [2*FB+1:0]     st [2];
	logic [FB-1:0]       s [2];
	logic [WEIGHT_W-1:0] w [2];
	logic [WEIGHT_W-1:0] w_s2 [2];
	logic [WEIGHT_W:0]   wv [2];
	logic [WEIGHT_W:0]   uv [2];
	logic [WPROD_W-1:0]  wprod_s3 [NUM_CORNERS];

	always_comb begin
		sq[0] = x_frac * x_frac;
		sq[1] = y_frac * y_frac;
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			f_s1[0] <= x_frac;
			f_s1[1] <= y_frac;
			f2_s1[0] <= sq[0][2*FB-1:FB];
			f2_s1[1] <= sq[1][2*FB-1:FB];
		end
	end

	// s = f2 * (3 - 2f), always below one, so the upper product bits are zero.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			t[k] = THREE_ONE - {1'b0, f_s1[k], 1'b0};
			st[k] = f2_s1[k] * t[k];
			s[k] = st[k][2*FB-1:FB];
		end
	end

	generate
		if (FB >= WEIGHT_W) begin : g_trunc
			always_comb begin
				for (int k = 0; k < 2; k++) begin
					w[k] = s[k][FB-1 -: WEIGHT_W];
				end
			end
		end else begin : g_widen
			always_comb begin
				for (int k = 0; k < 2; k++) begin
					w[k] = {s[k], {(WEIGHT_W-FB){1'b0}}};
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			w_s2 <= w;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			wv[k] = {1'b0, w_s2[k]};
			uv[k] = UNIT - wv[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			wprod_s3[CORNER_A] <= uv[0] * uv[1];
			wprod_s3[CORNER_B] <= wv[0] * uv[1];
			wprod_s3[CORNER_C] <= uv[0] * wv[1];
			wprod_s3[CORNER_D] <= wv[0] * wv[1];
		end
	end

	assign wprod = wprod_s3;

endmodule

`default_nettype wire

@@ rtl/vns_blend.sv @@
// Bilinear blend: corner times weight product, four-way sum, scale and clamp.
// Depends on vns_pkg; holds the output register of the block.
`default_nettype none

module vns_blend (
	input  wire logic                          clk,
	input  wire vns_pkg::adv_t                 adv,
	input  wire logic [vns_pkg::CORNER_W-1:0]  corner [vns_pkg::NUM_CORNERS],
	input  wire logic [vns_pkg::WPROD_W-1:0]   wprod [vns_pkg::NUM_CORNERS],
	output logic [vns_pkg::NOISE_W-1:0]        noise_value
);
	import vns_pkg::*;

	localparam int SUM_W = BPROD_W + 2;

	logic [BPROD_W-1:0]     prod [NUM_CORNERS];
	logic [BPROD_W-1:0]     prod_s4 [NUM_CORNERS];
	logic [SUM_W-1:0]       sum;
	logic [SUM_W-17:0]      scaled;
	logic [NOISE_W-1:0]     clamped;
	logic [NOISE_W-1:0]     noise_s5;

	always_comb begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			prod[k] = BPROD_W'(corner[k]) * BPROD_W'(wprod[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			prod_s4 <= prod;
		end
	end

	always_comb begin
		sum = SUM_W'(prod_s4[CORNER_A]) + SUM_W'(prod_s4[CORNER_B])
			+ SUM_W'(prod_s4[CORNER_C]) + SUM_W'(prod_s4[CORNER_D]);
		scaled = sum[SUM_W-1:16];
		if (scaled > (SUM_W-16)'(OUT_MAX)) begin
			clamped = OUT_MAX;
		end else begin
			clamped = scaled[NOISE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			noise_s5 <= clamped;
		end
	end

	assign noise_value = noise_s5;

endmodule

`default_nettype wire

@@ rtl/value_noise_sampler_unit.sv @@
// Top level of the value noise sampler: seed register, stage valid chain, datapath.
// Depends on vns_pkg, vns_hash, vns_ease and vns_blend.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  x_coord, y_coord (signed Q16.16)
// noise     out        noise_valid/noise_ready    noise_value (Q10.16, clamped)
// seed      in         noise_seed_we              noise_seed
//
// Each request passes five register stages before its result is shown; one request
// can enter every clock unless every stage is full and the output stalls.
// The corner hash takes three stages (two 32-bit multiplies split by the xorshift),
// with the eased weights built alongside; the blend adds two more.
// Reset clears the seed and all stage valid bits; payload registers are not reset.
// A stalled output holds its result; each stage keeps loading while it or the one
// below has room, so bubbles close up and new requests are taken during a stall.
module value_noise_sampler_unit #(
	parameter int FRAC_BITS = vns_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire logic [vns_pkg::COORD_W-1:0]   x_coord,
	input  wire logic [vns_pkg::COORD_W-1:0]   y_coord,
	output logic                               noise_valid,
	input  wire logic                          noise_ready,
	output logic [vns_pkg::NOISE_W-1:0]        noise_value,
	input  wire logic                          noise_seed_we,
	input  wire logic [31:0]                   noise_seed
);
	import vns_pkg::*;

	// The seed only ever enters the hash multiplied by its constant, so the
	// product is what gets stored.
	logic [31:0] seed_mix_q;
	logic [31:0] seed_prod;

	assign seed_prod = noise_seed * HASH_K3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_mix_q <= '0;
		end else if (noise_seed_we) begin
			seed_mix_q <= seed_prod;
		end
	end

	// Stage valid bits. A stage loads when it is empty or the stage below it
	// is moving; the same condition is the load enable of its data registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	adv_t adv;

	always_comb begin
		adv.s5 = !v_s5 || noise_ready;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= sample_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	assign sample_ready = adv.s1;
	assign noise_valid = v_s5;

	// Lattice cell is the floor of each coordinate, an arithmetic shift; the
	// fraction is the bits below the binary point.
	logic [COORD_W-1:0] x_cell;
	logic [COORD_W-1:0] y_cell;

	assign x_cell = COORD_W'($signed(x_coord) >>> FRAC_BITS);
	assign y_cell = COORD_W'($signed(y_coord) >>> FRAC_BITS);

	logic [CORNER_W-1:0] corner [NUM_CORNERS];
	logic [WPROD_W-1:0]  wprod [NUM_CORNERS];

	vns_hash u_hash (
		.clk      (clk),
		.adv      (adv),
		.x_cell   (x_cell),
		.y_cell   (y_cell),
		.seed_mix (seed_mix_q),
		.corner   (corner)
	);

	vns_ease #(
		.FRAC_BITS (FRAC_BITS)
	) u_ease (
		.clk    (clk),
		.adv    (adv),
		.x_frac (x_coord[FRAC_BITS-1:0]),
		.y_frac (y_coord[FRAC_BITS-1:0]),
		.wprod  (wprod)
	);

	vns_blend u_blend (
		.clk         (clk),
		.adv         (adv),
		.corner      (corner),
		.wprod       (wprod),
		.noise_value (noise_value)
	);

	// The clamp keeps every result inside the documented range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> noise_value <= OUT_MAX)
		else $error("noise_value above full scale");

	// Requests are refused only when every stage is full and the output stalls.
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !noise_ready))
		else $error("sample refused with room in the pipeline");

	// A result taken with nothing in the stage above leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(noise_valid && noise_ready && !v_s4) |=> !noise_valid)
		else $error("result repeated after it was taken");

	// An accepted request always occupies the first stage next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> v_s1)
		else $error("accepted sample lost at entry");

endmodule

`default_nettype wire

@@ sim/value_noise_sampler_unit_tb.sv @@
// Self-checking testbench for value_noise_sampler_unit: random and directed sample requests,
// with an in-bench noise predictor and a queue of expected results.
// Depends on vns_pkg and the value noise sampler RTL.
`timescale 1ns / 100ps

module value_noise_sampler_unit_tb;

	import vns_pkg::*;

	// The block is built with its default fraction width, so the predictor uses the same.
	localparam int FRAC = FRAC_BITS_DEFAULT;
	localparam int RANDOM_PER_PHASE = 75;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic noise_valid;
	logic noise_ready = 1'b0;
	logic [NOISE_W-1:0] noise_value;
	logic noise_seed_we = 1'b0;
	logic [31:0] noise_seed = '0;

	// Requests still to be offered, and the noise values owed by the block in order.
	sample_t sample_queue[$];
	logic [NOISE_W-1:0] expected_noise[$];

	// Our copy of the seed register, updated only while the block is idle.
	logic [31:0] seed_model = '0;
	// Percent of cycles in which the sender holds back and the receiver stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned errors = 0;

	sample_t next_req;
	logic [NOISE_W-1:0] want;

	value_noise_sampler_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.noise_valid  (noise_valid),
		.noise_ready  (noise_ready),
		.noise_value  (noise_value),
		.noise_seed_we(noise_seed_we),
		.noise_seed   (noise_seed)
	);

	always #1 clk = ~clk;

	// Ten-bit lattice value of one corner: multiply-xorshift hash, all modulo 2^32.
	function automatic logic [CORNER_W-1:0] hash_corner(logic [31:0] i, logic [31:0] j,
			logic [31:0] seed);
		logic [31:0] h;
		h = i * HASH_K1 + j * HASH_K2 + seed * HASH_K3;
		h = (h ^ (h >> 13)) * HASH_K4;
		h = h ^ (h >> 16);
		return h[CORNER_W-1:0];
	endfunction

	// Smoothstep of the fractional part of a coordinate, as a Q0.16 weight.
	function automatic logic [63:0] ease_frac(logic [COORD_W-1:0] v);
		logic [63:0] one;
		logic [63:0] f;
		logic [63:0] f2;
		logic [63:0] t;
		logic [63:0] s;
		one = 64'd1 << FRAC;
		f = {32'd0, v} & (one - 64'd1);
		f2 = (f * f) >> FRAC;
		t = 64'd3 * one - 64'd2 * f;
		s = (f2 * t) >> FRAC;
		if (FRAC >= WEIGHT_W)
			return s >> (FRAC - WEIGHT_W);
		return s << (WEIGHT_W - FRAC);
	endfunction

	// Expected noise for one sample point: floor to the lattice cell, hash the four
	// corners, then blend them bilinearly with the eased weights and clamp.
	function automatic logic [NOISE_W-1:0] predict_noise(logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [31:0] seed);
		logic signed [COORD_W-1:0] xs;
		logic signed [COORD_W-1:0] ys;
		logic [31:0] xi;
		logic [31:0] yi;
		logic [63:0] wx;
		logic [63:0] wy;
		logic [63:0] ux;
		logic [63:0] uy;
		logic [63:0] ca;
		logic [63:0] cb;
		logic [63:0] cc;
		logic [63:0] cd;
		logic [63:0] sum;
		logic [63:0] r;
		xs = x;
		ys = y;
		xi = xs >>> FRAC;
		yi = ys >>> FRAC;
		wx = ease_frac(x);
		wy = ease_frac(y);
		ux = (64'd1 << WEIGHT_W) - wx;
		uy = (64'd1 << WEIGHT_W) - wy;
		// The corner one past the top lattice index needs no special case: the index sum is taken in 32 bits.
		ca = 64'(hash_corner(xi, yi, seed));
		cb = 64'(hash_corner(xi + 32'd1, yi, seed));
		cc = 64'(hash_corner(xi, yi + 32'd1, seed));
		cd = 64'(hash_corner(xi + 32'd1, yi + 32'd1, seed));
		sum = ca * ux * uy + cb * wx * uy + cc * ux * wy + cd * wx * wy;
		r = sum >> WEIGHT_W;
		// Truncation can never push the blend past the top corner value, but the
		// block still saturates, so the predictor does the same.
		if (r > 64'(OUT_MAX))
			r = 64'(OUT_MAX);
		return r[NOISE_W-1:0];
	endfunction

	// One random coordinate. Most draws are shaped to hit cell borders, fraction
	// extremes and the ends of the lattice; the rest cover every bit at random.
	function automatic logic [COORD_W-1:0] rand_coord();
		logic [31:0] r;
		logic [15:0] frac;
		logic [15:0] cell_hi;
		r = $urandom;
		case ($urandom_range(3))
			0: begin
				return r;
			end
			1: begin
				// A few cells either side of the origin.
				return {{12{r[19]}}, r[19:0]};
			end
			2: begin
				case ($urandom_range(5))
					0: frac = 16'h0000;
					1: frac = 16'h0001;
					2: frac = 16'h7FFF;
					3: frac = 16'h8000;
					4: frac = 16'hFFFF;
					default: frac = r[15:0];
				endcase
				return {r[31:16], frac};
			end
			default: begin
				case ($urandom_range(3))
					0: cell_hi = 16'h7FFF;
					1: cell_hi = 16'h8000;
					2: cell_hi = 16'hFFFF;
					default: cell_hi = 16'h0000;
				endcase
				return {cell_hi, r[15:0]};
			end
		endcase
	endfunction

	task automatic add_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		sample_t s;
		s.x = x;
		s.y = y;
		sample_queue.push_back(s);
	endtask

	// Waits until every request has been offered and accepted, and every owed
	// result has come back. Checked at the falling edge so the clocked driver and
	// monitor have finished their work for the cycle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || sample_valid || expected_noise.size() != 0);
	endtask

	// Seed writes happen only while the pipeline is empty, so every prediction made
	// at acceptance time uses the seed the block also uses.
	task automatic write_seed(logic [31:0] value);
		@(posedge clk);
		noise_seed_we <= 1'b1;
		noise_seed <= value;
		seed_model = value;
		@(posedge clk);
		noise_seed_we <= 1'b0;
	endtask

	// Driver. A request is taken at an edge where valid and ready are both high;
	// the expected noise is predicted right then. Once valid is raised it stays up
	// with the same coordinates until the block takes the request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_ready) begin
			if (sample_valid)
				expected_noise.push_back(predict_noise(x_coord, y_coord, seed_model));
			if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = sample_queue.pop_front();
				sample_valid <= 1'b1;
				x_coord <= next_req.x;
				y_coord <= next_req.y;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Monitor. Every result taken is compared with the oldest expectation; a result
	// that nobody asked for is an error too. Ready is redrawn every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_ready <= 1'b0;
		end else begin
			if (noise_valid && noise_ready) begin
				if (expected_noise.size() == 0) begin
					$display("%0t: unexpected noise result, expected none, got %0d",
						$time, noise_value);
					errors++;
				end else begin
					want = expected_noise.pop_front();
					if (noise_value !== want) begin
						$display("%0t: noise_value mismatch, expected %0d, got %0d",
							$time, want, noise_value);
						errors++;
					end
				end
			end
			noise_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus. Six phases, each with its own seed: the first two with a bursty
	// sender and a heavily stalled receiver, the next two the other way round, and
	// the last two at full rate. The seeds include both ends of the register range.
	initial begin
		logic [31:0] phase_seed[NUM_PHASES];
		phase_seed[0] = 32'h0000_0000;
		phase_seed[1] = 32'hFFFF_FFFF;
		phase_seed[2] = $urandom;
		phase_seed[3] = 32'h8000_0000;
		phase_seed[4] = $urandom;
		phase_seed[5] = 32'h0000_0001;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 2) begin
				send_idle_pct = 33;
				recv_idle_pct = 63;
			end else if (p < 4) begin
				send_idle_pct = 63;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_seed(phase_seed[p]);
			@(negedge clk);

			if (p == 0) begin
				// Origin, the far corners of the coordinate space, and mixed signs.
				add_sample(32'h0000_0000, 32'h0000_0000);
				add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
				add_sample(32'h8000_0000, 32'h8000_0000);
				add_sample(32'h7FFF_FFFF, 32'h8000_0000);
				add_sample(32'h8000_0000, 32'h7FFF_FFFF);
				add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
				// Top lattice index, whose next corner lies past the cell range, and cell minus one.
				add_sample(32'h7FFF_0000, 32'h7FFF_8000);
				add_sample(32'h7FFF_C000, 32'h0000_0000);
				add_sample(32'hFFFF_0000, 32'hFFFF_0001);
				// Fraction extremes: just above, at half and just below a cell edge.
				add_sample(32'h0000_0001, 32'h0000_0001);
				add_sample(32'h0000_8000, 32'h0000_8000);
				add_sample(32'h0000_FFFF, 32'h0000_FFFF);
				add_sample(32'h0000_7FFF, 32'h0003_8001);
				add_sample(32'hFFFF_8000, 32'h0001_0000);
				add_sample(32'h0001_0000, 32'hFFFF_8000);
				add_sample(32'h8000_FFFF, 32'h8000_0001);
				// Near-saturation candidate with fractions close to one at a seed of zero, and a mixed bit pattern.
				add_sample(32'h1234_FFFF, 32'h5678_FFFF);
				add_sample(32'hA5A5_5A5A, 32'h5A5A_A5A5);
			end

			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				add_sample(rand_coord(), rand_coord());

			wait_drained();
		end

		// Let the pipeline settle in case anything stray is still on its way out.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest plausible run.
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/vns_pkg.sv
rtl/vns_hash.sv
rtl/vns_ease.sv
rtl/vns_blend.sv
rtl/value_noise_sampler_unit.sv
sim/value_noise_sampler_unit_tb.sv
